### hdl/mvsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsr_pkg
// Shared types, shape vertex table, arctangent table and the per-vertex
// micro-op schedule for the mesh vertex scale/rotate block.
// ----------------------------------------------------------------------------
package mvsr_pkg;

    // Fixed table geometry
    localparam int TABLE_KINDS  = 5;
    localparam int TABLE_POINTS = 12;
    localparam int TABLE_SIZE   = TABLE_KINDS * TABLE_POINTS;
    localparam int MAX_STEPS    = 24;

    // CORDIC start gain, Q1.30
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    // Sine/cosine, dx/dy, product, accumulator and pixel widths
    localparam int TRIG_W = 33;
    localparam int OFS_W  = 32;
    localparam int PROD_W = 49;
    localparam int ACC_W  = 66;
    localparam int PIX_W  = 35;

    // Per-vertex schedule: steps 0..9 issue products, 10 drains, 11 rounds, 12 emits
    localparam int          STEP_W     = 4;
    localparam logic [3:0]  STEP_ROUND = 4'd11;
    localparam logic [3:0]  STEP_EMIT  = 4'd12;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_VERTEX
    } t_state;

    typedef enum logic [1:0] {
        A_W,
        A_H,
        A_DX,
        A_DY
    } t_asel;

    typedef enum logic [2:0] {
        B_TX,
        B_TY,
        B_CLO,
        B_CHI,
        B_SLO,
        B_SHI
    } t_bsel;

    typedef enum logic [2:0] {
        DEST_NONE,
        DEST_DX,
        DEST_DY,
        DEST_ACCX,
        DEST_ACCY
    } t_dest;

    // One multiply-accumulate operation
    typedef struct packed {
        t_asel asel;
        t_bsel bsel;
        t_dest dest;
        logic  shift;   // product weighted by 2^16 (upper half of sin/cos)
        logic  neg;     // subtract instead of add
        logic  load;    // replace accumulator instead of adding
    } t_mac_op;

    localparam t_mac_op MAC_NOP = '{asel: A_W, bsel: B_TX, dest: DEST_NONE,
                                    shift: 1'b0, neg: 1'b0, load: 1'b0};

    // Normalized vertices, Q0.16, flat [kind*12 + point]
    localparam logic [15:0] SHAPE_X [0:TABLE_SIZE-1] = '{
        16'd16384, 16'd32768, 16'd49152, 16'd32768, 16'd16384, 16'd16384,
        16'd16384, 16'd16384, 16'd16384, 16'd16384, 16'd16384, 16'd16384,
        16'd19661, 16'd26214, 16'd45875, 16'd52429, 16'd45875, 16'd19661,
        16'd6554,  16'd19661, 16'd19661, 16'd19661, 16'd19661, 16'd19661,
        16'd19661, 16'd26214, 16'd32768, 16'd45875, 16'd52429, 16'd52429,
        16'd45875, 16'd39322, 16'd19661, 16'd13107, 16'd13107, 16'd19661,
        16'd19661, 16'd26214, 16'd52429, 16'd52429, 16'd45875, 16'd32768,
        16'd32768, 16'd26214, 16'd19661, 16'd13107, 16'd13107, 16'd19661,
        16'd26214, 16'd39322, 16'd52429, 16'd52429, 16'd39322, 16'd26214,
        16'd13107, 16'd13107, 16'd26214, 16'd26214, 16'd26214, 16'd26214
    };

    localparam logic [15:0] SHAPE_Y [0:TABLE_SIZE-1] = '{
        16'd52429, 16'd13107, 16'd52429, 16'd45875, 16'd52429, 16'd52429,
        16'd52429, 16'd52429, 16'd52429, 16'd52429, 16'd52429, 16'd52429,
        16'd26214, 16'd13107, 16'd13107, 16'd32768, 16'd52429, 16'd52429,
        16'd32768, 16'd26214, 16'd26214, 16'd26214, 16'd26214, 16'd26214,
        16'd19661, 16'd26214, 16'd13107, 16'd13107, 16'd26214, 16'd39322,
        16'd39322, 16'd52429, 16'd52429, 16'd45875, 16'd32768, 16'd19661,
        16'd13107, 16'd13107, 16'd26214, 16'd32768, 16'd39322, 16'd39322,
        16'd45875, 16'd52429, 16'd52429, 16'd39322, 16'd26214, 16'd13107,
        16'd13107, 16'd13107, 16'd26214, 16'd39322, 16'd52429, 16'd52429,
        16'd39322, 16'd26214, 16'd13107, 16'd13107, 16'd13107, 16'd13107
    };

    // Vertex coordinate lookup; out-of-table kinds read as zero
    function automatic logic [15:0] shape_coord(input logic [2:0] kind,
                                                input logic [3:0] pt,
                                                input logic       sel_y);
        logic [6:0] idx;
        idx = 7'(kind) * 7'(TABLE_POINTS) + 7'(pt);
        if (idx < 7'(TABLE_SIZE)) begin
            return sel_y ? SHAPE_Y[idx[5:0]] : SHAPE_X[idx[5:0]];
        end
        return 16'd0;
    endfunction

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [32:0] atan_turn(input logic [4:0] i);
        unique case (i)
            5'd0:    return 33'sd536870912;
            5'd1:    return 33'sd316933406;
            5'd2:    return 33'sd167458907;
            5'd3:    return 33'sd85004756;
            5'd4:    return 33'sd42667331;
            5'd5:    return 33'sd21354465;
            5'd6:    return 33'sd10679838;
            5'd7:    return 33'sd5340245;
            5'd8:    return 33'sd2670163;
            5'd9:    return 33'sd1335087;
            5'd10:   return 33'sd667544;
            5'd11:   return 33'sd333772;
            5'd12:   return 33'sd166886;
            5'd13:   return 33'sd83443;
            5'd14:   return 33'sd41722;
            5'd15:   return 33'sd20861;
            5'd16:   return 33'sd10430;
            5'd17:   return 33'sd5215;
            5'd18:   return 33'sd2608;
            5'd19:   return 33'sd1304;
            5'd20:   return 33'sd652;
            5'd21:   return 33'sd326;
            5'd22:   return 33'sd163;
            5'd23:   return 33'sd81;
            default: return 33'sd0;
        endcase
    endfunction

    // Per-vertex schedule of the shared multiplier:
    //   dx = w*(tx-0.5), dy = h*(ty-0.5)
    //   acc_x = dx*c - dy*s, acc_y = dx*s + dy*c (sin/cos split in 16-bit halves)
    function automatic t_mac_op vertex_op(input logic [3:0] step);
        t_mac_op op;
        op = MAC_NOP;
        unique case (step)
            4'd0: op = '{A_W,  B_TX,  DEST_DX,   1'b0, 1'b0, 1'b1};
            4'd1: op = '{A_H,  B_TY,  DEST_DY,   1'b0, 1'b0, 1'b1};
            4'd2: op = '{A_DX, B_CLO, DEST_ACCX, 1'b0, 1'b0, 1'b1};
            4'd3: op = '{A_DX, B_CHI, DEST_ACCX, 1'b1, 1'b0, 1'b0};
            4'd4: op = '{A_DX, B_SLO, DEST_ACCY, 1'b0, 1'b0, 1'b1};
            4'd5: op = '{A_DX, B_SHI, DEST_ACCY, 1'b1, 1'b0, 1'b0};
            4'd6: op = '{A_DY, B_SLO, DEST_ACCX, 1'b0, 1'b1, 1'b0};
            4'd7: op = '{A_DY, B_SHI, DEST_ACCX, 1'b1, 1'b1, 1'b0};
            4'd8: op = '{A_DY, B_CLO, DEST_ACCY, 1'b0, 1'b0, 1'b0};
            4'd9: op = '{A_DY, B_CHI, DEST_ACCY, 1'b1, 1'b0, 1'b0};
            default: op = MAC_NOP;
        endcase
        return op;
    endfunction

endpackage

### hdl/mvsr_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsr_cordic
// Iterative CORDIC in rotation mode, one micro-rotation per cycle. Angle is
// a 16-bit fraction of a turn; the top two bits select a quarter turn that
// is applied after the iterations. Outputs cosine and sine in Q1.30.
// ----------------------------------------------------------------------------
module mvsr_cordic #(
    parameter int STEPS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [15:0]                        i_angle,
    output logic                               o_done,
    output logic signed [mvsr_pkg::TRIG_W-1:0] o_cos,
    output logic signed [mvsr_pkg::TRIG_W-1:0] o_sin
);

    localparam int TW = mvsr_pkg::TRIG_W;
    localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);

    typedef enum logic [1:0] {
        Q_0,
        Q_90,
        Q_180,
        Q_270
    } t_quad;

    logic                 r_run;
    logic                 r_map;
    logic                 r_done;
    logic [4:0]           r_i;
    logic [1:0]           r_quad;
    logic signed [TW-1:0] r_x;
    logic signed [TW-1:0] r_y;
    logic signed [TW-1:0] r_z;
    logic signed [TW-1:0] r_cos;
    logic signed [TW-1:0] r_sin;

    logic signed [TW-1:0] xs;
    logic signed [TW-1:0] ys;
    logic signed [TW-1:0] at;
    logic signed [TW-1:0] n_cos;
    logic signed [TW-1:0] n_sin;

    // Shifted terms for the current micro-rotation (floor shift)
    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;
    assign at = mvsr_pkg::atan_turn(r_i);

    // Quarter-turn rotation of the result
    always_comb begin
        unique case (t_quad'(r_quad))
            Q_0: begin
                n_cos = r_x;
                n_sin = r_y;
            end
            Q_90: begin
                n_cos = -r_y;
                n_sin = r_x;
            end
            Q_180: begin
                n_cos = -r_x;
                n_sin = -r_y;
            end
            Q_270: begin
                n_cos = r_y;
                n_sin = -r_x;
            end
            default: begin
                n_cos = r_x;
                n_sin = r_y;
            end
        endcase
    end

    // Control: run STEPS micro-rotations, then apply the quadrant
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_map  <= 1'b0;
            r_done <= 1'b0;
            r_i    <= 5'd0;
        end else begin
            r_done <= r_map;
            r_map  <= r_run && (r_i == LAST_STEP);
            if (i_start) begin
                r_run <= 1'b1;
                r_i   <= 5'd0;
            end else if (r_run) begin
                if (r_i == LAST_STEP) begin
                    r_run <= 1'b0;
                end
                r_i <= r_i + 5'd1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= mvsr_pkg::CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= TW'({i_angle[13:0], 16'd0});
            r_quad <= i_angle[15:14];
        end else if (r_run) begin
            if (!r_z[TW-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
        if (r_map) begin
            r_cos <= n_cos;
            r_sin <= n_sin;
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

### hdl/mvsr_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvsr_mac
// Shared 32x17 signed multiplier with a registered product and one
// accumulate adder. Results land in the offset registers (dx, dy) or in
// the two rotation accumulators, as the issued operation directs.
// ----------------------------------------------------------------------------
module mvsr_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mvsr_pkg::t_mac_op                 i_op,
    input  logic signed [mvsr_pkg::OFS_W-1:0] i_a,
    input  logic signed [16:0]                i_b,
    output logic signed [mvsr_pkg::OFS_W-1:0] o_dx,
    output logic signed [mvsr_pkg::OFS_W-1:0] o_dy,
    output logic signed [mvsr_pkg::ACC_W-1:0] o_acc_x,
    output logic signed [mvsr_pkg::ACC_W-1:0] o_acc_y
);

    localparam int PW = mvsr_pkg::PROD_W;
    localparam int AW = mvsr_pkg::ACC_W;
    localparam int OW = mvsr_pkg::OFS_W;

    mvsr_pkg::t_mac_op    r_op;
    logic signed [PW-1:0] r_prod;
    logic signed [OW-1:0] r_dx;
    logic signed [OW-1:0] r_dy;
    logic signed [AW-1:0] r_acc_x;
    logic signed [AW-1:0] r_acc_y;

    logic signed [PW-1:0] prod;
    logic signed [AW-1:0] ext;
    logic signed [AW-1:0] addend;
    logic signed [AW-1:0] base;
    logic signed [AW-1:0] sum;

    // Multiply stage
    assign prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= mvsr_pkg::MAC_NOP;
        end else begin
            r_op <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
    end

    // Accumulate stage: base + (+/- product * 2^0 or 2^16)
    always_comb begin
        ext    = AW'(r_prod);
        ext    = r_op.shift ? (ext <<< 16) : ext;
        addend = r_op.neg ? ~ext : ext;
        if (r_op.load) begin
            base = '0;
        end else if (r_op.dest == mvsr_pkg::DEST_ACCX) begin
            base = r_acc_x;
        end else begin
            base = r_acc_y;
        end
        sum = base + addend + AW'(r_op.neg);
    end

    always_ff @(posedge i_clk) begin
        unique case (r_op.dest)
            mvsr_pkg::DEST_DX:   r_dx    <= OW'(r_prod);
            mvsr_pkg::DEST_DY:   r_dy    <= OW'(r_prod);
            mvsr_pkg::DEST_ACCX: r_acc_x <= sum;
            mvsr_pkg::DEST_ACCY: r_acc_y <= sum;
            default: begin
            end
        endcase
    end

    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
    assign o_acc_x = r_acc_x;
    assign o_acc_y = r_acc_y;

endmodule

### hdl/mesh_vertex_scale_rotate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_vertex_scale_rotate
// Emits the polyline of one vector shape, scaled to a box and rotated
// about the box center.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An inactive request
// or an unknown shape kind is taken and produces nothing; busy stays low.
// Otherwise busy stays high while the iterative CORDIC computes sine and
// cosine (CORDIC_STEPS micro-rotations, at most MAX_STEPS) and then while
// every vertex in turn runs through the one shared multiplier (ten
// products, one drain, rounding, output), until the last vertex is out. Each
// vertex appears on the o_point_* ports for exactly one cycle with o_valid
// high; there is no backpressure, so the receiver must take every transfer
// in the cycle it is presented. o_last marks the final vertex.
// ----------------------------------------------------------------------------
module mesh_vertex_scale_rotate #(
    parameter int POINTS_PER_SHAPE = 12,
    parameter int SHAPE_KINDS      = 5,
    parameter int CORDIC_STEPS     = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_mesh_type,
    input  logic [15:0]        i_box_width,
    input  logic [15:0]        i_box_height,
    input  logic [15:0]        i_angle,
    input  logic               i_active,
    output logic               o_valid,
    output logic signed [17:0] o_point_x,
    output logic signed [17:0] o_point_y,
    output logic [3:0]         o_vertex_index,
    output logic               o_last
);

    localparam int STEPS_RUN = (CORDIC_STEPS < mvsr_pkg::MAX_STEPS) ?
                               CORDIC_STEPS : mvsr_pkg::MAX_STEPS;
    localparam int VW = $clog2(POINTS_PER_SHAPE);
    localparam int IW = (VW > 4) ? VW : 4;
    localparam logic [VW-1:0] LAST_VTX = VW'(POINTS_PER_SHAPE - 1);
    localparam int TW = mvsr_pkg::TRIG_W;
    localparam int XW = mvsr_pkg::PIX_W;
    localparam int OW = mvsr_pkg::OFS_W;
    localparam int AW = mvsr_pkg::ACC_W;

    // Control and request registers
    mvsr_pkg::t_state       r_state, n_state;
    logic [mvsr_pkg::STEP_W-1:0] r_step, n_step;
    logic [VW-1:0]          r_vtx, n_vtx;
    logic [15:0]            r_w;
    logic [15:0]            r_h;
    logic [2:0]             r_kind;
    logic signed [XW-1:0]   r_rx;
    logic signed [XW-1:0]   r_ry;
    logic                   r_valid, n_valid;
    logic signed [17:0]     r_px;
    logic signed [17:0]     r_py;
    logic [3:0]             r_idx;
    logic                   r_last;

    logic                   accept;
    logic                   go;
    logic                   kind_ok;
    logic                   cordic_done;
    logic signed [TW-1:0]   cos_v;
    logic signed [TW-1:0]   sin_v;
    mvsr_pkg::t_mac_op      op;
    logic signed [OW-1:0]   mac_a;
    logic signed [16:0]     mac_b;
    logic signed [OW-1:0]   dx;
    logic signed [OW-1:0]   dy;
    logic signed [AW-1:0]   acc_x;
    logic signed [AW-1:0]   acc_y;
    logic [IW-1:0]          vtx_ext;
    logic [3:0]             pt;
    logic signed [16:0]     tx_ofs;
    logic signed [16:0]     ty_ofs;
    logic signed [XW-1:0]   cx;
    logic signed [XW-1:0]   cy;
    logic signed [XW-1:0]   adj_x;
    logic signed [XW-1:0]   adj_y;

    // Truncated pixel value clamped to -65536..131071
    function automatic logic signed [17:0] sat18(input logic signed [18:0] v);
        if (v < -19'sd65536) begin
            return -18'sd65536;
        end else if (v > 19'sd131071) begin
            return 18'sd131071;
        end
        return 18'(v);
    endfunction

    // Request acceptance
    assign busy    = (r_state != mvsr_pkg::ST_IDLE);
    assign accept  = start && !busy;
    assign kind_ok = (4'(i_mesh_type) < 4'(SHAPE_KINDS)) &&
                     (4'(i_mesh_type) < 4'(mvsr_pkg::TABLE_KINDS));
    assign go      = accept && i_active && kind_ok;

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_w    <= i_box_width;
            r_h    <= i_box_height;
            r_kind <= i_mesh_type;
        end
    end

    // Sine and cosine
    mvsr_cordic #(
        .STEPS (STEPS_RUN)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (go),
        .i_angle (i_angle),
        .o_done  (cordic_done),
        .o_cos   (cos_v),
        .o_sin   (sin_v)
    );

    // Table point for the current vertex; past the table the last one repeats
    assign vtx_ext = IW'(r_vtx);
    assign pt      = (vtx_ext < IW'(mvsr_pkg::TABLE_POINTS)) ? vtx_ext[3:0] :
                     4'(mvsr_pkg::TABLE_POINTS - 1);
    assign tx_ofs  = signed'({1'b0, mvsr_pkg::shape_coord(r_kind, pt, 1'b0)}) -
                     17'sd32768;
    assign ty_ofs  = signed'({1'b0, mvsr_pkg::shape_coord(r_kind, pt, 1'b1)}) -
                     17'sd32768;

    // Operand selection for the shared multiplier
    assign op = (r_state == mvsr_pkg::ST_VERTEX) ? mvsr_pkg::vertex_op(r_step) :
                mvsr_pkg::MAC_NOP;

    always_comb begin
        unique case (op.asel)
            mvsr_pkg::A_W:  mac_a = signed'(OW'(r_w));
            mvsr_pkg::A_H:  mac_a = signed'(OW'(r_h));
            mvsr_pkg::A_DX: mac_a = dx;
            mvsr_pkg::A_DY: mac_a = dy;
            default:        mac_a = dx;
        endcase
        unique case (op.bsel)
            mvsr_pkg::B_TX:  mac_b = tx_ofs;
            mvsr_pkg::B_TY:  mac_b = ty_ofs;
            mvsr_pkg::B_CLO: mac_b = signed'({1'b0, cos_v[15:0]});
            mvsr_pkg::B_CHI: mac_b = cos_v[TW-1:16];
            mvsr_pkg::B_SLO: mac_b = signed'({1'b0, sin_v[15:0]});
            mvsr_pkg::B_SHI: mac_b = sin_v[TW-1:16];
            default:         mac_b = tx_ofs;
        endcase
    end

    mvsr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_dx    (dx),
        .o_dy    (dy),
        .o_acc_x (acc_x),
        .o_acc_y (acc_y)
    );

    // Rotated offset back to Q16.16 plus box center
    assign cx = XW'({r_w, 15'd0});
    assign cy = XW'({r_h, 15'd0});

    always_ff @(posedge i_clk) begin
        if (r_state == mvsr_pkg::ST_VERTEX && r_step == mvsr_pkg::STEP_ROUND) begin
            r_rx <= XW'(acc_x >>> 30) + cx;
            r_ry <= XW'(acc_y >>> 30) + cy;
        end
    end

    // Truncate toward zero: bias negative values before the shift
    assign adj_x = r_rx[XW-1] ? (r_rx + XW'(16'hFFFF)) : r_rx;
    assign adj_y = r_ry[XW-1] ? (r_ry + XW'(16'hFFFF)) : r_ry;

    // Sequencer: state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mvsr_pkg::ST_IDLE;
            r_step  <= '0;
            r_vtx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_vtx   <= n_vtx;
            r_valid <= n_valid;
        end
    end

    // Sequencer: next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_vtx   = r_vtx;
        n_valid = 1'b0;
        unique case (r_state)
            mvsr_pkg::ST_IDLE: begin
                if (go) begin
                    n_state = mvsr_pkg::ST_CORDIC;
                end
            end
            mvsr_pkg::ST_CORDIC: begin
                if (cordic_done) begin
                    n_state = mvsr_pkg::ST_VERTEX;
                    n_step  = '0;
                    n_vtx   = '0;
                end
            end
            mvsr_pkg::ST_VERTEX: begin
                if (r_step == mvsr_pkg::STEP_EMIT) begin
                    n_valid = 1'b1;
                    n_step  = '0;
                    n_vtx   = r_vtx + VW'(1);
                    if (r_vtx == LAST_VTX) begin
                        n_state = mvsr_pkg::ST_IDLE;
                    end
                end else begin
                    n_step = r_step + 4'd1;
                end
            end
            default: begin
                n_state = mvsr_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (n_valid) begin
            r_px   <= sat18(19'(adj_x >>> 16));
            r_py   <= sat18(19'(adj_y >>> 16));
            r_idx  <= vtx_ext[3:0];
            r_last <= (r_vtx == LAST_VTX);
        end
    end

    assign o_valid        = r_valid;
    assign o_point_x      = r_px;
    assign o_point_y      = r_py;
    assign o_vertex_index = r_idx;
    assign o_last         = r_last;

endmodule
